@@ hw/rtl/b2da_pkg.sv @@
// Shared types and constants for the binary to decimal ASCII formatter.
package b2da_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_DIGITS_DEF  = 20;

    localparam int IN_VALUE_W = 64;
    localparam int COUNT_W    = 5;
    localparam int CHAR_W     = 6;
    localparam int BCD_W      = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [BCD_W-1:0]  DABBLE_MIN = 4'd5;
    localparam logic [BCD_W-1:0]  DABBLE_ADD = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_LENGTH,
        ST_EMIT,
        ST_EMPTY
    } b2da_state_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic unload;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/b2da_channels.sv @@
// Handshake channels for the formatter input and result words.
interface b2da_in_if;
    logic                              valid;
    logic                              ready;
    logic [b2da_pkg::IN_VALUE_W-1:0]   value;
    logic [b2da_pkg::COUNT_W-1:0]      capacity;

    modport source (output valid, output value, output capacity, input ready);
    modport sink   (input valid, input value, input capacity, output ready);
endinterface

interface b2da_out_if;
    logic                              valid;
    logic                              ready;
    logic [b2da_pkg::CHAR_W-1:0]       character;
    logic [b2da_pkg::COUNT_W-1:0]      position;
    logic [b2da_pkg::COUNT_W-1:0]      digit_count;
    logic                              empty_res;
    logic                              last;

    modport source (output valid, output character, output position, output digit_count,
                    output empty_res, output last, input ready);
    modport sink   (input valid, input character, input position, input digit_count,
                    input empty_res, input last, output ready);
endinterface

@@ hw/rtl/binary_to_decimal_ascii_top.sv @@
// Top level of the binary to decimal ASCII formatter.
//
// Takes one word of an unsigned value and a digit capacity, and returns its decimal
// digits as ASCII characters, least significant first, one result word per digit.
// Each result carries its buffer position (0 is leftmost), the digit count, and last on
// the word at position 0. The count is the natural decimal length (1 for zero) capped
// at the capacity, which itself saturates at MAX_DIGITS; when the cap applies the low
// digits are kept. A zero capacity gives a single word flagged empty_res. Conversion
// runs in a row of MAX_DIGITS BCD cells fed one value bit per cycle, most significant
// first, with add-3 correction in every cell; the row then shifts its digits down one
// cell per result. A zero capacity skips the conversion and the cell row entirely.
// A new word is taken in the cycle after the final result is registered, while that
// result still waits at the output. Only the low VALUE_WIDTH bits of value are used.
module binary_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    b2da_in_if.sink    in_ch,
    b2da_out_if.source out_ch
);
    import b2da_pkg::*;

    localparam int BIT_CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    b2da_state_t state_reg;
    b2da_state_t state_next;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [COUNT_W-1:0]     cap_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     pos_reg;
    logic                   overflow_reg;

    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      out_char_reg;
    logic [COUNT_W-1:0]     out_pos_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic                   out_empty_reg;
    logic                   out_last_reg;

    cell_ctrl_t             ctrl;
    logic                   accept;
    logic                   slot_free;
    logic                   emit_fire;
    logic                   empty_fire;
    logic [COUNT_W-1:0]     cap_sat;
    logic [COUNT_W-1:0]     len_calc;
    logic [COUNT_W-1:0]     digits_calc;

    logic [BCD_W-1:0]       digit [MAX_DIGITS];
    logic                   carry [MAX_DIGITS];

    // ---------------------------------------------------------------- cell row
    // Cell 0 holds the units digit: it takes the next value bit while converting and
    // drives the result character while unloading; every cell passes its digit down.
    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        logic             bit_in;
        logic [BCD_W-1:0] digit_in;

        if (i == 0)
        begin : g_first
            assign bit_in = value_reg[VALUE_WIDTH-1];
        end
        else
        begin : g_inner
            assign bit_in = carry[i-1];
        end

        if (i == MAX_DIGITS - 1)
        begin : g_top
            assign digit_in = '0;
        end
        else
        begin : g_below
            assign digit_in = digit[i+1];
        end

        b2da_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .bit_in    (bit_in),
            .digit_in  (digit_in),
            .digit     (digit[i]),
            .carry_out (carry[i])
        );
    end

    // ---------------------------------------------------------------- length
    // Highest non-zero digit sets the natural length; a carry lost off the top cell
    // means the value has more digits than the row, so the cap always applies.
    always_comb
    begin
        len_calc = COUNT_W'(1);
        for (int i = 1; i < MAX_DIGITS; i++)
        begin
            if (digit[i] != '0)
            begin
                len_calc = COUNT_W'(i + 1);
            end
        end
        if (overflow_reg)
        begin
            len_calc = COUNT_W'(MAX_DIGITS);
        end
    end

    assign digits_calc = (len_calc > cap_reg) ? cap_reg : len_calc;
    assign cap_sat     = (in_ch.capacity > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS)
                                                                 : in_ch.capacity;

    // ---------------------------------------------------------------- control
    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = (cap_sat == '0) ? ST_EMPTY : ST_DABBLE;
                end
            end
            ST_DABBLE:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_LENGTH;
                end
            end
            ST_LENGTH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free && pos_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        accept      = in_ch.ready && in_ch.valid;
        emit_fire   = (state_reg == ST_EMIT) && slot_free;
        empty_fire  = (state_reg == ST_EMPTY) && slot_free;
        ctrl.clear  = accept;
        ctrl.dabble = (state_reg == ST_DABBLE);
        ctrl.unload = emit_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg  <= '0;
            overflow_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                bit_cnt_reg  <= BIT_CNT_W'(VALUE_WIDTH - 1);
                overflow_reg <= 1'b0;
            end
            else if (ctrl.dabble)
            begin
                bit_cnt_reg  <= bit_cnt_reg - BIT_CNT_W'(1);
                overflow_reg <= overflow_reg | carry[MAX_DIGITS-1];
            end

            if (state_reg == ST_LENGTH)
            begin
                pos_reg <= digits_calc - COUNT_W'(1);
            end
            else if (emit_fire)
            begin
                pos_reg <= pos_reg - COUNT_W'(1);
            end
        end
    end

    // hold the value and feed it out most significant bit first
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= in_ch.value[VALUE_WIDTH-1:0];
            cap_reg   <= cap_sat;
        end
        else if (ctrl.dabble)
        begin
            value_reg <= value_reg << 1;
        end

        if (state_reg == ST_LENGTH)
        begin
            count_reg <= digits_calc;
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire || empty_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_char_reg  <= ASCII_ZERO + CHAR_W'(digit[0]);
            out_pos_reg   <= pos_reg;
            out_count_reg <= count_reg;
            out_empty_reg <= 1'b0;
            out_last_reg  <= (pos_reg == '0);
        end
        else if (empty_fire)
        begin
            out_char_reg  <= '0;
            out_pos_reg   <= '0;
            out_count_reg <= '0;
            out_empty_reg <= 1'b1;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.character   = out_char_reg;
    assign out_ch.position    = out_pos_reg;
    assign out_ch.digit_count = out_count_reg;
    assign out_ch.empty_res   = out_empty_reg;
    assign out_ch.last        = out_last_reg;

    // ---------------------------------------------------------------- assertions
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_empty_reg |-> out_last_reg && out_count_reg == '0)
        else $error("empty result word without last or with a digit count");

    a_digit_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_empty_reg |->
            out_pos_reg < out_count_reg && out_char_reg >= ASCII_ZERO
            && out_char_reg <= ASCII_ZERO + CHAR_W'(9))
        else $error("digit result word out of range");

    a_last_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_empty_reg |-> out_last_reg == (out_pos_reg == '0))
        else $error("last flag disagrees with position");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> pos_reg < count_reg && count_reg <= cap_reg)
        else $error("unload position beyond digit count");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("new word taken before the previous item finished");

endmodule

@@ hw/rtl/b2da_cell.sv @@
// One BCD digit cell of the shift-add-3 row.
module b2da_cell (
    input  logic                        clk,
    input  b2da_pkg::cell_ctrl_t        ctrl,
    input  logic                        bit_in,
    input  logic [b2da_pkg::BCD_W-1:0]  digit_in,
    output logic [b2da_pkg::BCD_W-1:0]  digit,
    output logic                        carry_out
);
    import b2da_pkg::*;

    logic [BCD_W-1:0] digit_reg;
    logic [BCD_W-1:0] digit_next;
    logic [BCD_W-1:0] adjusted;

    // add three before the shift so the digit carries at ten
    assign adjusted  = (digit_reg >= DABBLE_MIN) ? digit_reg + DABBLE_ADD : digit_reg;
    assign carry_out = adjusted[BCD_W-1];
    assign digit     = digit_reg;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adjusted[BCD_W-2:0], bit_in};
        end
        else if (ctrl.unload)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

@@ test/binary_to_decimal_ascii_top_tb.sv @@
// Self-checking testbench for the binary to decimal ASCII formatter.
module binary_to_decimal_ascii_top_tb;

    import b2da_pkg::*;

    localparam int VALUE_WIDTH = VALUE_WIDTH_DEF;
    localparam int MAX_DIGITS  = MAX_DIGITS_DEF;
    localparam logic [IN_VALUE_W-1:0] VALUE_MASK = {IN_VALUE_W{1'b1}} >> (64 - VALUE_WIDTH);

    // Quiet period after the last result, ample to expose a stray word.
    localparam int DRAIN_TAIL   = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_WORDS = 72;
    localparam int MAX_REPORTS  = 200;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] value;
        logic [COUNT_W-1:0]    capacity;
    } format_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  character;
        logic [COUNT_W-1:0] position;
        logic [COUNT_W-1:0] digit_count;
        logic               empty_res;
        logic               last;
    } digit_word_t;

    logic clk;
    logic rst_n;

    b2da_in_if  in_ch ();
    b2da_out_if out_ch ();

    binary_to_decimal_ascii_top #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Words waiting to be offered, and digit words the block still owes us.
    format_req_t pending_words[$];
    digit_word_t digits_due[$];

    int  queued_count = 0;   // words handed to the driver so far
    int  items_taken  = 0;   // words the block has accepted
    int  err_count    = 0;
    bit  in_word_taken = 1'b0;

    // Idle rates in percent, changed by the stimulus between phases.
    int  send_idle_pct = 0;
    int  stall_pct     = 0;

    // Long receiver hold-off: a toggle requests it, its own counter times it.
    bit  hold_req  = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung block; far beyond the slowest legal run.
    initial
    begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [IN_VALUE_W-1:0] pow10(input int k);
        logic [IN_VALUE_W-1:0] p;
        p = 1;
        for (int i = 0; i < k; i++)
            p = p * 10;
        return p;
    endfunction

    // Work out the digit words one request produces, lowest digit first.
    function automatic void predict_digits(input logic [IN_VALUE_W-1:0] value,
                                           input logic [COUNT_W-1:0] capacity);
        logic [IN_VALUE_W-1:0] v;
        logic [IN_VALUE_W-1:0] t;
        int                    cap;
        int                    len;
        digit_word_t           w;
        v   = value & VALUE_MASK;
        cap = capacity;
        if (cap > MAX_DIGITS)
            cap = MAX_DIGITS;
        // Zero capacity: a single empty word and nothing else.
        if (cap == 0)
        begin
            w.character   = '0;
            w.position    = '0;
            w.digit_count = '0;
            w.empty_res   = 1'b1;
            w.last        = 1'b1;
            digits_due.push_back(w);
            return;
        end
        len = 1;
        t   = v;
        while (t >= 10)
        begin
            t = t / 10;
            len++;
        end
        // Truncation keeps only the low-order digits.
        if (len > cap)
            len = cap;
        for (int k = 0; k < len; k++)
        begin
            w.character   = ASCII_ZERO + CHAR_W'(v % 10);
            w.position    = COUNT_W'(len - 1 - k);
            w.digit_count = COUNT_W'(len);
            w.empty_res   = 1'b0;
            w.last        = (len - 1 - k == 0);
            v = v / 10;
            digits_due.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [IN_VALUE_W-1:0] got,
                                   input logic [IN_VALUE_W-1:0] want);
        if (err_count < MAX_REPORTS)
            $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        err_count++;
    endtask

    // Scoreboard: check the result word first, then log any accepted input word,
    // both in one process so the queue is never touched from two places.
    always @(posedge clk)
    begin
        digit_word_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (digits_due.size() == 0)
                report_mismatch("result word with nothing due", out_ch.character, 0);
            else
            begin
                w = digits_due.pop_front();
                if (out_ch.character !== w.character)
                    report_mismatch("character", out_ch.character, w.character);
                if (out_ch.position !== w.position)
                    report_mismatch("position", out_ch.position, w.position);
                if (out_ch.digit_count !== w.digit_count)
                    report_mismatch("digit_count", out_ch.digit_count, w.digit_count);
                if (out_ch.empty_res !== w.empty_res)
                    report_mismatch("empty_res", out_ch.empty_res, w.empty_res);
                if (out_ch.last !== w.last)
                    report_mismatch("last", out_ch.last, w.last);
            end
        end
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predict_digits(in_ch.value, in_ch.capacity);
            items_taken   <= items_taken + 1;
            in_word_taken <= 1'b1;
        end
        else
            in_word_taken <= 1'b0;
    end

    // Driver: hold an offered word until it is taken, then advance to the next
    // pending word or stay idle, chosen at random at the phase's rate.
    always @(negedge clk)
    begin
        format_req_t nxt;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid && !in_word_taken)
        begin
            // hold: the word on the channel has not been taken yet
        end
        else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            nxt = pending_words.pop_front();
            in_ch.valid    <= 1'b1;
            in_ch.value    <= nxt.value;
            in_ch.capacity <= nxt.capacity;
        end
        else
        begin
            // Drop valid and scramble the payload so it cannot be mistaken for data.
            in_ch.valid    <= 1'b0;
            in_ch.value    <= {$urandom, $urandom};
            in_ch.capacity <= COUNT_W'($urandom);
        end
    end

    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: stall at random, and all the time while a hold-off is running.
    always @(negedge clk)
    begin
        out_ch.ready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    task automatic push_word(input logic [IN_VALUE_W-1:0] value,
                             input logic [COUNT_W-1:0] capacity);
        format_req_t r;
        r.value    = value;
        r.capacity = capacity;
        pending_words.push_back(r);
        queued_count++;
    endtask

    // Spread values over every magnitude, with the decade edges well covered.
    function automatic logic [IN_VALUE_W-1:0] rand_value();
        int k;
        k = $urandom_range(19);
        case ($urandom_range(9))
            0: return IN_VALUE_W'($urandom_range(20));
            1: return pow10(k);
            2: return pow10(k + 1) - 1;
            3: return {IN_VALUE_W{1'b1}};
            default: return {$urandom, $urandom} >> $urandom_range(63);
        endcase
    endfunction

    // Mostly legal capacities, some zero, some beyond the limit.
    function automatic logic [COUNT_W-1:0] rand_capacity();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return '0;
        else if (r < 16)
            return COUNT_W'($urandom_range(31, MAX_DIGITS + 1));
        else
            return COUNT_W'($urandom_range(MAX_DIGITS, 1));
    endfunction

    // Wait until every word has been taken and every digit has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_taken != queued_count || digits_due.size() != 0);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
        @(posedge clk);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        // Start the hold-off before the words go in, so the block fills and stalls.
        if (with_hold)
            hold_req = ~hold_req;
        for (int i = 0; i < RANDOM_WORDS; i++)
            push_word(rand_value(), rand_capacity());
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.value     = '0;
        in_ch.capacity  = '0;
        out_ch.ready    = 1'b0;
        repeat (11) @(posedge clk);
        // Release reset away from the sampling edge.
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: field extremes, zero, decade edges, saturation,
        // truncation and the empty result.
        push_word(0, 1);
        push_word(0, 20);
        push_word(0, 0);
        push_word({IN_VALUE_W{1'b1}}, 0);
        push_word({IN_VALUE_W{1'b1}}, 20);
        push_word({IN_VALUE_W{1'b1}}, 31);
        push_word({IN_VALUE_W{1'b1}}, 21);
        push_word({IN_VALUE_W{1'b1}}, 5);
        push_word({IN_VALUE_W{1'b1}}, 1);
        push_word(9, 1);
        push_word(10, 1);
        push_word(10, 2);
        push_word(99, 2);
        push_word(100, 2);
        push_word(pow10(19), 20);
        push_word(pow10(19) - 1, 20);
        push_word(pow10(19) - 1, 19);
        push_word(12345, 3);
        push_word(12345, 5);
        push_word(12345, 6);
        push_word(1, 0);
        push_word(7, 31);
        wait_drained();

        // Random phases; each drains fully before the next changes the idle rates.
        run_phase(0, 0, 1'b0);
        run_phase(79, 0, 1'b0);
        run_phase(0, 79, 1'b0);
        run_phase(33, 33, 1'b0);
        run_phase(0, 0, 1'b1);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
